FILE: rtl/isort_pkg.sv
`timescale 1ns / 1ps

package isort_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_item;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      last_of_run;
		logic                      overflow_seen;
	} result_t;

	typedef struct packed {
		logic insert;
		logic shift_down;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/isort_cell.sv
`timescale 1ns / 1ps

module isort_cell
	import isort_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cell_ctrl_t                ctrl,
	input  logic signed [VALUE_W-1:0] ins_value,
	input  logic signed [VALUE_W-1:0] prev_value,
	input  logic                      prev_valid,
	input  logic                      prev_gt,
	input  logic signed [VALUE_W-1:0] next_value,
	input  logic                      next_valid,
	output logic signed [VALUE_W-1:0] value,
	output logic                      valid,
	output logic                      gt
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;

	// empty cells count as larger than anything
	assign gt = !valid_q || (value_q > ins_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_down) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= valid_q || !prev_gt || prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_down) begin
			value_q <= next_value;
		end else if (ctrl.insert && gt) begin
			value_q <= prev_gt ? prev_value : ins_value;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

FILE: rtl/insertion_sorter.sv
`timescale 1ns / 1ps

// channel  | ports                  | handshake
// ---------+------------------------+---------------------------------
// input    | item (item_t)          | beat when start && !busy
// output   | result (result_t)      | beat when strobe
//
// a value that is not last is inserted while there is room; busy stays low.
// a last item is inserted too while there is room, then the chain shifts
// toward cell 0, one result per cycle, n results in all (n = stored count).
// busy is high while results go out; the receiver cannot stall.
// reset clears the valid bits, the count, the overflow flag and the state.
module insertion_sorter
	import isort_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	state_t            state_q;
	state_t            state_nxt;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              accept;
	logic              full;
	logic              last_beat;
	cell_ctrl_t        ctrl;

	logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
	logic                      cell_valid [MAX_ITEMS];
	logic                      cell_gt    [MAX_ITEMS];

	assign accept    = start && !busy;
	assign full      = (count_q == CNT_W'(MAX_ITEMS));
	assign last_beat = (count_q == CNT_W'(1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.last_item) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (last_beat) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = 1'b0;
		strobe          = 1'b0;
		ctrl.insert     = 1'b0;
		ctrl.shift_down = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctrl.insert = accept && !full;
			end
			ST_EMIT: begin
				busy            = 1'b1;
				strobe          = 1'b1;
				ctrl.shift_down = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.shift_down) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept && full) begin
				ovf_q <= 1'b1;
			end else if (ctrl.shift_down && last_beat) begin
				ovf_q <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_value;
		logic                      prev_valid;
		logic                      prev_gt;
		logic signed [VALUE_W-1:0] next_value;
		logic                      next_valid;

		if (i == 0) begin : g_head
			assign prev_value = '0;
			assign prev_valid = 1'b0;
			assign prev_gt    = 1'b0;
		end else begin : g_body
			assign prev_value = cell_value[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_gt    = cell_gt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_value = cell_value[i+1];
			assign next_valid = cell_valid[i+1];
		end

		isort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.ins_value  (item.value),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.prev_gt    (prev_gt),
			.next_value (next_value),
			.next_valid (next_valid),
			.value      (cell_value[i]),
			.valid      (cell_valid[i]),
			.gt         (cell_gt[i])
		);
	end

	assign result.sorted_value  = cell_value[0];
	assign result.last_of_run   = last_beat;
	assign result.overflow_seen = ovf_q;

	a_strobe_valid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> cell_valid[0])
		else $error("result beat from an empty head cell");

	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_item) |=> strobe)
		else $error("last item did not start the result run");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last_of_run) |=> (!strobe && count_q == '0 && !ovf_q))
		else $error("result run did not end cleanly");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("fill count beyond capacity");

endmodule

FILE: test/sort_checker.sv
`timescale 1ns / 1ps

module sort_checker
	import isort_pkg::*;
#(
	parameter int DEPTH = MAX_ITEMS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    strobe,
	input  result_t result,
	output int      failures,
	output int      pending
);

	logic signed [VALUE_W-1:0] held_values [DEPTH];
	int                        held_count;
	logic                      dropped;
	result_t                   sorted_due [$];
	result_t                   due;

	task automatic insert_sorted(input item_t it);
		int pos;
		result_t r;
		if (held_count >= DEPTH) begin
			dropped = 1'b1;
		end else begin
			pos = held_count;
			while (pos > 0 && held_values[pos-1] > it.value) begin
				held_values[pos] = held_values[pos-1];
				pos--;
			end
			held_values[pos] = it.value;
			held_count++;
		end
		if (it.last_item) begin
			for (int k = 0; k < held_count; k++) begin
				r.sorted_value  = held_values[k];
				r.last_of_run   = (k == held_count - 1);
				r.overflow_seen = dropped;
				sorted_due.push_back(r);
			end
			held_count = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			dropped = 1'b0;
			sorted_due.delete();
			pending = 0;
			failures = 0;
		end else begin
			if (strobe) begin
				if (sorted_due.size() == 0) begin
					$error("result beat with nothing expected: sorted_value %0d",
						result.sorted_value);
					failures++;
				end else begin
					due = sorted_due.pop_front();
					if (result.sorted_value !== due.sorted_value) begin
						$error("sorted_value expected %0d actual %0d",
							due.sorted_value, result.sorted_value);
						failures++;
					end
					if (result.last_of_run !== due.last_of_run) begin
						$error("last_of_run expected %0b actual %0b",
							due.last_of_run, result.last_of_run);
						failures++;
					end
					if (result.overflow_seen !== due.overflow_seen) begin
						$error("overflow_seen expected %0b actual %0b",
							due.overflow_seen, result.overflow_seen);
						failures++;
					end
				end
			end
			if (start && !busy)
				insert_sorted(item);
			pending = sorted_due.size();
		end
	end

endmodule

FILE: test/insertion_sorter_test.sv
`timescale 1ns / 1ps

module insertion_sorter_test;
	import isort_pkg::*;

	localparam int DEPTH = MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 200;
	localparam int CALM_FROM = 170;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    strobe;
	result_t result;
	int      failures;
	int      pending;
	int      cycles = 0;
	bit      idle_on = 1'b1;

	always #5 clk = ~clk;

	insertion_sorter #(
		.MAX_ITEMS(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.strobe(strobe),
		.result(result)
	);

	sort_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.strobe  (strobe),
		.result  (result),
		.failures(failures),
		.pending (pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// called right after a falling edge; returns right after a falling edge
	task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item.value = v;
		item.last_item = last;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain;
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DEPTH + 4) @(negedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 8)) - 4;
			1: case ($urandom_range(0, 3))
				0: return 32'sh7fff_ffff;
				1: return 32'sh8000_0000;
				2: return 0;
				default: return -1;
			endcase
			2: return $signed($urandom_range(0, 40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent;
		int set_no;
		int len;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed sets
		send_value(7, 1'b1);
		send_value(32'sh7fff_ffff, 1'b0);
		send_value(32'sh8000_0000, 1'b0);
		send_value(0, 1'b0);
		send_value(-1, 1'b0);
		send_value(1, 1'b0);
		send_value(32'sh8000_0000, 1'b0);
		send_value(32'sh7fff_ffff, 1'b1);
		send_value(3, 1'b0);
		send_value(3, 1'b0);
		send_value(-3, 1'b0);
		send_value(3, 1'b1);
		for (int i = 5; i >= 1; i--)
			send_value(i, i == 1);
		for (int i = 1; i <= 3; i++)
			send_value(-i * 1000, i == 3);
		drain();

		// random sets; the first three fill the store, the first and third past capacity
		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			case (set_no)
				0: len = DEPTH + 1;
				1: len = DEPTH;
				2: len = DEPTH + 3;
				default: len = ($urandom_range(0, 9) == 0) ?
					$urandom_range(DEPTH - 2, DEPTH + 4) : $urandom_range(1, 10);
			endcase
			for (int i = 0; i < len; i++) begin
				if (sent >= CALM_FROM)
					idle_on = 1'b0;
				send_value(rand_value(), i == len - 1);
				sent++;
			end
			if (set_no == 4)
				drain();
			set_no++;
		end
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
